[design/cst_pkg.sv]
// Shared types and constants for the character stream tokenizer.
// Holds the token kind codes, the token record and the per-item token batch.
// No dependencies; every other design file imports this package.
package cst_pkg;

  // Default width of the character position counter and run start.
  localparam int POS_BITS_DEF = 16;

  // Offsets and lengths leave the block at this fixed width, saturating.
  localparam int OUT_BITS = 16;
  localparam logic [OUT_BITS-1:0] OUT_MAX = {OUT_BITS{1'b1}};

  // One item yields a flushed run, a one-character token or a second flush,
  // and the end token: never more than three results.
  localparam int MAX_TOKENS = 3;
  localparam int CNT_BITS = 2;

  typedef enum logic [3:0] {
    KIND_LPAREN      = 4'd0,
    KIND_RPAREN      = 4'd1,
    KIND_LBRACKET    = 4'd2,
    KIND_RBRACKET    = 4'd3,
    KIND_COMMA       = 4'd4,
    KIND_STMT_END    = 4'd5,
    KIND_SCOPE_BEGIN = 4'd6,
    KIND_SCOPE_END   = 4'd7,
    KIND_OP          = 4'd8,
    KIND_NAME        = 4'd9,
    KIND_END         = 4'd10
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [OUT_BITS-1:0] start;
    logic [OUT_BITS-1:0] len;
  } token_t;

  // Tokens of one input item, packed from entry 0, with their count.
  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tok;
    logic [CNT_BITS-1:0]     cnt;
  } batch_t;

endpackage

[design/cst_token_gen.sv]
// Run state and token generation for the character stream tokenizer.
// Classifies one character, updates the open run and builds the token batch.
// Depends on cst_pkg.
module cst_token_gen #(
  parameter int POSITION_BITS = cst_pkg::POS_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic            has_char,
  input  logic [7:0]      char_code,
  input  logic            eos,
  output cst_pkg::batch_t batch
);
  import cst_pkg::*;

  localparam int EXT_BITS = (POSITION_BITS > OUT_BITS) ? POSITION_BITS : OUT_BITS;

  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_CR       = 8'h0D;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_BANG     = 8'h21;
  localparam logic [7:0] CH_AMP      = 8'h26;
  localparam logic [7:0] CH_LPAREN   = 8'h28;
  localparam logic [7:0] CH_RPAREN   = 8'h29;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_PLUS     = 8'h2B;
  localparam logic [7:0] CH_COMMA    = 8'h2C;
  localparam logic [7:0] CH_MINUS    = 8'h2D;
  localparam logic [7:0] CH_DOT      = 8'h2E;
  localparam logic [7:0] CH_SLASH    = 8'h2F;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_LT       = 8'h3C;
  localparam logic [7:0] CH_EQ       = 8'h3D;
  localparam logic [7:0] CH_GT       = 8'h3E;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_RBRACKET = 8'h5D;
  localparam logic [7:0] CH_LBRACE   = 8'h7B;
  localparam logic [7:0] CH_BAR      = 8'h7C;
  localparam logic [7:0] CH_RBRACE   = 8'h7D;

  typedef enum logic [2:0] {
    MODE_IDLE = 3'b001,
    MODE_OP   = 3'b010,
    MODE_NAME = 3'b100
  } mode_t;

  typedef struct packed {
    logic  ws;
    logic  single;
    logic  op;
    kind_t kind;
  } char_class_t;

  function automatic char_class_t classify(input logic [7:0] c);
    char_class_t r;
    r = '{ws: 1'b0, single: 1'b0, op: 1'b0, kind: KIND_NAME};
    case (c) inside
      [CH_TAB:CH_CR], CH_SPACE: r.ws = 1'b1;
      CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_EQ, CH_DOT,
      CH_AMP, CH_BAR, CH_BANG, CH_GT, CH_LT: r.op = 1'b1;
      CH_LPAREN:   begin r.single = 1'b1; r.kind = KIND_LPAREN;      end
      CH_RPAREN:   begin r.single = 1'b1; r.kind = KIND_RPAREN;      end
      CH_LBRACKET: begin r.single = 1'b1; r.kind = KIND_LBRACKET;    end
      CH_RBRACKET: begin r.single = 1'b1; r.kind = KIND_RBRACKET;    end
      CH_COMMA:    begin r.single = 1'b1; r.kind = KIND_COMMA;       end
      CH_SEMI:     begin r.single = 1'b1; r.kind = KIND_STMT_END;    end
      CH_LBRACE:   begin r.single = 1'b1; r.kind = KIND_SCOPE_BEGIN; end
      CH_RBRACE:   begin r.single = 1'b1; r.kind = KIND_SCOPE_END;   end
      default:     r.kind = KIND_NAME;
    endcase
    return r;
  endfunction

  function automatic logic [OUT_BITS-1:0] sat_out(input logic [POSITION_BITS-1:0] v);
    logic [EXT_BITS-1:0] x;
    x = EXT_BITS'(v);
    if (x > EXT_BITS'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return x[OUT_BITS-1:0];
  endfunction

  mode_t                    mode_r, mode_nxt, mode_mid;
  logic [POSITION_BITS-1:0] start_r, start_nxt, start_mid;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt, pos_mid;
  char_class_t              cls;
  logic                     f1_v, s_v, f2_v, m_v;
  token_t                   f1_tok, mid_tok, end_tok;

  always_comb begin
    cls       = classify(char_code);
    f1_v      = 1'b0;
    s_v       = 1'b0;
    mode_mid  = mode_r;
    start_mid = start_r;
    pos_mid   = pos_r;

    if (has_char) begin
      if (pos_r != {POSITION_BITS{1'b1}}) begin
        pos_mid = pos_r + 1'b1;
      end
      if (cls.ws) begin
        f1_v     = (mode_r != MODE_IDLE);
        mode_mid = MODE_IDLE;
      end else if (cls.single) begin
        // A brace inside a name run is part of the name.
        if (!(mode_r == MODE_NAME &&
              (cls.kind == KIND_SCOPE_BEGIN || cls.kind == KIND_SCOPE_END))) begin
          f1_v     = (mode_r != MODE_IDLE);
          s_v      = 1'b1;
          mode_mid = MODE_IDLE;
        end
      end else if (cls.op) begin
        if (mode_r != MODE_OP) begin
          f1_v      = (mode_r != MODE_IDLE);
          mode_mid  = MODE_OP;
          start_mid = pos_r;
        end
      end else begin
        if (mode_r != MODE_NAME) begin
          f1_v      = (mode_r != MODE_IDLE);
          mode_mid  = MODE_NAME;
          start_mid = pos_r;
        end
      end
    end

    f1_tok.kind  = (mode_r == MODE_OP) ? KIND_OP : KIND_NAME;
    f1_tok.start = sat_out(start_r);
    f1_tok.len   = sat_out(pos_r - start_r);

    // The second slot holds either the one-character token or the run that
    // the end of the stream flushes; an item never needs both.
    f2_v = eos && (mode_mid != MODE_IDLE);
    if (s_v) begin
      mid_tok.kind  = cls.kind;
      mid_tok.start = sat_out(pos_r);
      mid_tok.len   = OUT_BITS'(1);
    end else begin
      mid_tok.kind  = (mode_mid == MODE_OP) ? KIND_OP : KIND_NAME;
      mid_tok.start = sat_out(start_mid);
      mid_tok.len   = sat_out(pos_mid - start_mid);
    end
    m_v = s_v || f2_v;

    end_tok.kind  = KIND_END;
    end_tok.start = sat_out(pos_mid);
    end_tok.len   = '0;

    batch.cnt    = CNT_BITS'(f1_v) + CNT_BITS'(m_v) + CNT_BITS'(eos);
    batch.tok[0] = f1_v ? f1_tok : (m_v ? mid_tok : end_tok);
    batch.tok[1] = (f1_v && m_v) ? mid_tok : end_tok;
    batch.tok[2] = end_tok;

    if (eos) begin
      mode_nxt  = MODE_IDLE;
      start_nxt = '0;
      pos_nxt   = '0;
    end else begin
      mode_nxt  = mode_mid;
      start_nxt = start_mid;
      pos_nxt   = pos_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      start_r <= '0;
      pos_r   <= '0;
    end else if (take) begin
      mode_r  <= mode_nxt;
      start_r <= start_nxt;
      pos_r   <= pos_nxt;
    end
  end

  // An open run never starts beyond the current character count.
  assert property (@(posedge clk) disable iff (!rst_n) start_r <= pos_r)
    else $error("run start is past the character position");

  // The end of the stream returns the run state to its reset values.
  assert property (@(posedge clk) disable iff (!rst_n)
    (take && eos) |=> (pos_r == '0 && start_r == '0 && mode_r == MODE_IDLE))
    else $error("state not cleared after end of stream");

endmodule

[design/cst_batch_buf.sv]
// Result buffer for the character stream tokenizer.
// Holds the token batch of one item and hands it out one token per request.
// Depends on cst_pkg.
module cst_batch_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load,
  input  cst_pkg::batch_t batch,
  output logic            ready,
  output logic            out_valid,
  input  logic            out_stall,
  output cst_pkg::token_t out_tok,
  output logic            out_last
);
  import cst_pkg::*;

  token_t [MAX_TOKENS-1:0] tok_r, tok_nxt;
  logic [CNT_BITS-1:0]     cnt_r, cnt_nxt;
  logic [CNT_BITS-1:0]     idx_r, idx_nxt;
  logic                    pop, done;

  always_comb begin
    out_valid = (cnt_r != '0);
    pop       = out_valid && !out_stall;
    out_last  = (idx_r == cnt_r - 1'b1);
    done      = pop && out_last;
    ready     = !out_valid || done;

    case (idx_r)
      2'd0:    out_tok = tok_r[0];
      2'd1:    out_tok = tok_r[1];
      default: out_tok = tok_r[2];
    endcase

    tok_nxt = tok_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      tok_nxt = batch.tok;
      cnt_nxt = batch.cnt;
      idx_nxt = '0;
    end else if (done) begin
      cnt_nxt = '0;
      idx_nxt = '0;
    end else if (pop) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    tok_r <= tok_nxt;
  end

  // The read pointer stays inside the batch that is being delivered.
  assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> (idx_r < cnt_r))
    else $error("token index beyond batch count");

  // A batch is only replaced once its last token has been taken.
  assert property (@(posedge clk) disable iff (!rst_n) !ready |=> $stable(tok_r))
    else $error("batch overwritten before it drained");

endmodule

[design/char_stream_tokenizer_top.sv]
// An accepted character passes through the input register, then the token batch register,
// to the output port. Throughput: one item per cycle while each item yields at most one
// token and the output is not stalled; an item that yields n tokens, n at most three,
// holds the single-token output port until all n tokens have left.
// Reset (rst_n low, synchronous): no open run, position zero, both registers empty.
// Top level of the character stream tokenizer; depends on cst_pkg, cst_token_gen, cst_batch_buf.
module char_stream_tokenizer_top #(
  parameter int POSITION_BITS = cst_pkg::POS_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_has_char,
  input  logic [7:0]  in_char_code,
  input  logic        in_end_of_stream,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_token_kind,
  output logic [15:0] out_start_offset,
  output logic [15:0] out_token_length,
  output logic        out_last_token
);
  import cst_pkg::*;

  // The input register holds one request. It is consumed as soon as the
  // result buffer can take its token batch, which is at once when the buffer
  // is empty or its last token leaves in the same cycle, so requests flow
  // back to back while the output keeps up.
  logic       in_vld_r, in_vld_nxt;
  logic       has_r;
  logic [7:0] code_r;
  logic       eos_r;
  logic       in_take;
  logic       take;
  logic       buf_ready;
  batch_t     batch;
  token_t     out_tok;

  assign take     = in_vld_r && buf_ready;
  assign in_stall = in_vld_r && !buf_ready;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_take) begin
      in_vld_nxt = 1'b1;
    end else if (take) begin
      in_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else begin
      in_vld_r <= in_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      has_r  <= in_has_char;
      code_r <= in_char_code;
      eos_r  <= in_end_of_stream;
    end
  end

  // Classification and the run state update happen in one pass between the
  // input register and the batch register. An item that causes no token
  // still passes through and, if it carries a character, updates the position count.
  cst_token_gen #(
    .POSITION_BITS(POSITION_BITS)
  ) u_gen (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .has_char (has_r),
    .char_code(code_r),
    .eos      (eos_r),
    .batch    (batch)
  );

  // The batch register serves up to three tokens, one per output request,
  // and marks the final one of each item.
  cst_batch_buf u_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (take),
    .batch    (batch),
    .ready    (buf_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_tok  (out_tok),
    .out_last (out_last_token)
  );

  assign out_token_kind   = out_tok.kind;
  assign out_start_offset = out_tok.start;
  assign out_token_length = out_tok.len;

endmodule
